[hdl/fbc_pkg.sv]
// Shared types and constants for the frustum box cull test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

	// default number of frustum planes
	localparam int PLANE_COUNT_DEF = 6;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TEST = 1'b1;

	// number of pipeline registers from a test transfer to its result strobe
	localparam int RESULT_LATENCY = 6;

	// one stored plane: Q1.14 normal and Q.30 offset
	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [47:0] off;
	} plane_t;

	// plane write request from the top level to the plane store
	typedef struct packed {
		logic               en;
		logic [2:0]         idx;
		plane_t             plane;
	} plane_wr_t;

endpackage

`default_nettype wire

[hdl/frustum_box_cull_test_top.sv]
// Top level of the frustum box cull test: plane store plus box test pipeline.
// Depends on fbc_pkg, fbc_plane_regs and fbc_eval_pipe.
//
// Takes one transfer per clock and never holds start off, so busy is always
// low. A load writes one plane and gives no result; a plane index at or beyond
// PLANE_COUNT is ignored. A test gives one done strobe with inside_res,
// registered through the pipeline stages: capture, multipliers, per-axis max,
// partial sums, sign per plane and the result register. Results come out in
// transfer order and must be taken in the strobe cycle. A test sees every load
// transferred before it.
`timescale 1ns / 1ps
`default_nettype none

module frustum_box_cull_test_top
	import fbc_pkg::*;
#(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               req_type,
	input  wire logic [2:0]         plane_index,
	input  wire logic signed [15:0] normal_x,
	input  wire logic signed [15:0] normal_y,
	input  wire logic signed [15:0] normal_z,
	input  wire logic signed [47:0] plane_offset,
	input  wire logic signed [31:0] box_min_x,
	input  wire logic signed [31:0] box_min_y,
	input  wire logic signed [31:0] box_min_z,
	input  wire logic signed [31:0] box_max_x,
	input  wire logic signed [31:0] box_max_y,
	input  wire logic signed [31:0] box_max_z,
	output logic                    done,
	output logic                    inside_res
);

	plane_wr_t          wr;
	plane_t             planes [PLANE_COUNT];
	logic               test_fire;
	logic signed [31:0] box_lo [3];
	logic signed [31:0] box_hi [3];

	// never stalls
	assign busy = 1'b0;

	// transfer decode
	assign wr.en       = start && !busy && (req_type == REQ_LOAD);
	assign wr.idx      = plane_index;
	assign wr.plane.nx  = normal_x;
	assign wr.plane.ny  = normal_y;
	assign wr.plane.nz  = normal_z;
	assign wr.plane.off = plane_offset;
	assign test_fire   = start && !busy && (req_type == REQ_TEST);

	assign box_lo[0] = box_min_x;
	assign box_lo[1] = box_min_y;
	assign box_lo[2] = box_min_z;
	assign box_hi[0] = box_max_x;
	assign box_hi[1] = box_max_y;
	assign box_hi[2] = box_max_z;

	fbc_plane_regs #(
		.PLANE_COUNT(PLANE_COUNT)
	) u_planes (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.planes (planes)
	);

	fbc_eval_pipe #(
		.PLANE_COUNT(PLANE_COUNT)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.test_fire  (test_fire),
		.box_lo     (box_lo),
		.box_hi     (box_hi),
		.planes     (planes),
		.done       (done),
		.inside_res (inside_res)
	);

endmodule

`default_nettype wire

[hdl/fbc_plane_regs.sv]
// Plane store: flip-flop array of frustum planes, written by load transfers.
// Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc_plane_regs
	import fbc_pkg::*;
#(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire plane_wr_t wr,
	output plane_t         planes [PLANE_COUNT]
);

	plane_t planes_q [PLANE_COUNT];

	// a load with an index beyond the store matches no entry and is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				planes_q[p] <= '0;
			end
		end else if (wr.en) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				if (32'(wr.idx) == p) begin
					planes_q[p] <= wr.plane;
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

`default_nettype wire

[hdl/fbc_eval_pipe.sv]
// Box test pipeline: products, per-axis maxima, partial sums, plane signs, AND.
// Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc_eval_pipe
	import fbc_pkg::*;
#(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               test_fire,
	input  wire logic signed [31:0] box_lo [3],
	input  wire logic signed [31:0] box_hi [3],
	input  wire plane_t             planes [PLANE_COUNT],
	output logic                    done,
	output logic                    inside_res
);

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, done_q;

	// payload
	logic signed [31:0] lo_s1 [3];
	logic signed [31:0] hi_s1 [3];
	logic signed [47:0] plo_s2 [PLANE_COUNT][3];
	logic signed [47:0] phi_s2 [PLANE_COUNT][3];
	logic signed [47:0] off_s2 [PLANE_COUNT];
	logic signed [47:0] mx_s3  [PLANE_COUNT][3];
	logic signed [47:0] off_s3 [PLANE_COUNT];
	logic signed [48:0] sab_s4 [PLANE_COUNT];
	logic signed [48:0] scd_s4 [PLANE_COUNT];
	logic signed [49:0] tot_sum [PLANE_COUNT];
	logic [PLANE_COUNT-1:0] pin_s5;
	logic inside_q;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= test_fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done_q <= vld_s5;
		end
	end

	// s1: capture box corners
	always_ff @(posedge clk) begin
		if (test_fire) begin
			lo_s1 <= box_lo;
			hi_s1 <= box_hi;
		end
	end

	// s2: normal times min and max on each axis; snapshot offsets
	always_ff @(posedge clk) begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			plo_s2[p][0] <= planes[p].nx * lo_s1[0];
			phi_s2[p][0] <= planes[p].nx * hi_s1[0];
			plo_s2[p][1] <= planes[p].ny * lo_s1[1];
			phi_s2[p][1] <= planes[p].ny * hi_s1[1];
			plo_s2[p][2] <= planes[p].nz * lo_s1[2];
			phi_s2[p][2] <= planes[p].nz * hi_s1[2];
			off_s2[p]    <= planes[p].off;
		end
	end

	// s3: the dot is separable, so the best corner takes the larger term per axis
	always_ff @(posedge clk) begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			for (int a = 0; a < 3; a++) begin
				mx_s3[p][a] <= (phi_s2[p][a] > plo_s2[p][a]) ? phi_s2[p][a] : plo_s2[p][a];
			end
			off_s3[p] <= off_s2[p];
		end
	end

	// s4: partial sums, x+y and z-offset
	always_ff @(posedge clk) begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			sab_s4[p] <= 49'(mx_s3[p][0]) + 49'(mx_s3[p][1]);
			scd_s4[p] <= 49'(mx_s3[p][2]) - 49'(off_s3[p]);
		end
	end

	// full signed distance of the best corner
	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			tot_sum[p] = 50'(sab_s4[p]) + 50'(scd_s4[p]);
		end
	end

	// s5: plane keeps the box when the best corner is at or above it
	always_ff @(posedge clk) begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			pin_s5[p] <= ~tot_sum[p][49];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (vld_s5) begin
			inside_q <= &pin_s5;
		end
	end

	assign done       = done_q;
	assign inside_res = inside_q;

endmodule

`default_nettype wire

[hdl/fbc_checker.sv]
// Port-level checks for the frustum box cull test, bound to the top level.
// Depends on fbc_pkg and frustum_box_cull_test_top.
`timescale 1ns / 1ps
`default_nettype none

module fbc_checker
	import fbc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic req_type,
	input wire logic done
);

	// block never refuses a transfer
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every strobe traces back to a test transfer at fixed latency
	a_done_has_test: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (req_type == REQ_TEST), RESULT_LATENCY))
		else $error("result strobe without a test transfer");

	// every test transfer gets its strobe when reset stayed off meanwhile
	a_test_gets_done: assert property (@(posedge clk) disable iff (!arst_n)
		($past(start && !busy && (req_type == REQ_TEST), RESULT_LATENCY)
		 && $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3)
		 && $past(arst_n, 4) && $past(arst_n, 5) && $past(arst_n, 6)) |-> done)
		else $error("test transfer lost its result");

	// a load never yields a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && (req_type == REQ_LOAD), RESULT_LATENCY) |-> !done)
		else $error("load produced a result");

endmodule

bind frustum_box_cull_test_top fbc_checker u_fbc_checker (.*);

`default_nettype wire

[tb/sv/tb_frustum_box_cull_test_top.sv]
// Self-checking testbench for frustum_box_cull_test_top: plane loads and box tests.
// Depends on fbc_pkg (request codes, plane type, result latency) and the block RTL.
// The local plane table and fixed-point dot products predict inside_res for every test.
`timescale 1ns / 1ps

module tb_frustum_box_cull_test_top;
	import fbc_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	// one request as presented on the input ports
	typedef struct packed {
		logic               req_type;
		logic [2:0]         plane_index;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [47:0] off;
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
	} cull_req_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               req_type;
	logic [2:0]         plane_index;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic signed [47:0] plane_offset;
	logic signed [31:0] box_min_x;
	logic signed [31:0] box_min_y;
	logic signed [31:0] box_min_z;
	logic signed [31:0] box_max_x;
	logic signed [31:0] box_max_y;
	logic signed [31:0] box_max_z;
	logic               done;
	logic               inside_res;

	// predictor state and scoreboard
	plane_t plane_tbl [PLANE_COUNT_DEF];
	bit     inside_q [$];
	bit     inside_want;
	int     idle_pct    = 0;
	int     err_cnt     = 0;
	int     load_cnt    = 0;
	int     ignored_cnt = 0;
	int     test_cnt    = 0;
	int     kept_cnt    = 0;
	int     culled_cnt  = 0;
	int     eff_cnt     = 0;

	frustum_box_cull_test_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.plane_index  (plane_index),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.plane_offset (plane_offset),
		.box_min_x    (box_min_x),
		.box_min_y    (box_min_y),
		.box_min_z    (box_min_z),
		.box_max_x    (box_max_x),
		.box_max_y    (box_max_y),
		.box_max_z    (box_max_z),
		.done         (done),
		.inside_res   (inside_res)
	);

	always #5 clk = ~clk;

	// uniform value in [-half, half]
	function automatic int rand_span(input int half);
		return int'($urandom_range(0, 2 * half)) - half;
	endfunction

	// plane load; box fields carry junk
	function automatic cull_req_t mk_load(input logic [2:0] idx, input logic signed [15:0] x,
		input logic signed [15:0] y, input logic signed [15:0] z, input logic signed [47:0] o);
		cull_req_t r;
		r.req_type    = REQ_LOAD;
		r.plane_index = idx;
		r.nx          = x;
		r.ny          = y;
		r.nz          = z;
		r.off         = o;
		r.min_x       = $urandom;
		r.min_y       = $urandom;
		r.min_z       = $urandom;
		r.max_x       = $urandom;
		r.max_y       = $urandom;
		r.max_z       = $urandom;
		return r;
	endfunction

	// box test; plane fields carry junk
	function automatic cull_req_t mk_test(input int lx, input int ly, input int lz,
		input int hx, input int hy, input int hz);
		cull_req_t r;
		r.req_type    = REQ_TEST;
		r.plane_index = 3'($urandom);
		r.nx          = 16'($urandom);
		r.ny          = 16'($urandom);
		r.nz          = 16'($urandom);
		r.off         = 48'({$urandom, $urandom});
		r.min_x       = lx;
		r.min_y       = ly;
		r.min_z       = lz;
		r.max_x       = hx;
		r.max_y       = hy;
		r.max_z       = hz;
		return r;
	endfunction

	// box survives unless one plane has all eight corners strictly behind it
	function automatic bit cull_predict(input cull_req_t r);
		longint lo [3];
		longint hi [3];
		longint c [3];
		longint d;
		bit     any_in;
		bit     keep;
		lo[0] = r.min_x;
		lo[1] = r.min_y;
		lo[2] = r.min_z;
		hi[0] = r.max_x;
		hi[1] = r.max_y;
		hi[2] = r.max_z;
		keep  = 1'b1;
		for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
			any_in = 1'b0;
			for (int k = 0; k < 8; k++) begin
				c[0] = (k & 1) ? hi[0] : lo[0];
				c[1] = (k & 2) ? hi[1] : lo[1];
				c[2] = (k & 4) ? hi[2] : lo[2];
				d = longint'(plane_tbl[p].nx) * c[0] + longint'(plane_tbl[p].ny) * c[1]
					+ longint'(plane_tbl[p].nz) * c[2] - longint'(plane_tbl[p].off);
				if (d >= 0)
					any_in = 1'b1;
			end
			if (!any_in)
				keep = 1'b0;
		end
		return keep;
	endfunction

	// one transfer: random idle cycles, drive, wait for busy low, then predict
	task automatic send_req(input cull_req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start        = 1'b0;
			req_type     = 1'($urandom);
			plane_index  = 3'($urandom);
			normal_x     = 16'($urandom);
			normal_y     = 16'($urandom);
			normal_z     = 16'($urandom);
			plane_offset = 48'({$urandom, $urandom});
			box_min_x    = $urandom;
			box_min_y    = $urandom;
			box_min_z    = $urandom;
			box_max_x    = $urandom;
			box_max_y    = $urandom;
			box_max_z    = $urandom;
			@(negedge clk);
		end
		req_type     = r.req_type;
		plane_index  = r.plane_index;
		normal_x     = r.nx;
		normal_y     = r.ny;
		normal_z     = r.nz;
		plane_offset = r.off;
		box_min_x    = r.min_x;
		box_min_y    = r.min_y;
		box_min_z    = r.min_z;
		box_max_x    = r.max_x;
		box_max_y    = r.max_y;
		box_max_z    = r.max_z;
		start        = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (r.req_type == REQ_LOAD) begin
			if (r.plane_index < PLANE_COUNT_DEF) begin
				plane_tbl[r.plane_index] = '{nx: r.nx, ny: r.ny, nz: r.nz, off: r.off};
				load_cnt++;
				eff_cnt++;
			end else begin
				ignored_cnt++;
			end
		end else begin
			inside_q.push_back(cull_predict(r));
			test_cnt++;
			eff_cnt++;
		end
	endtask

	// stop sending and wait for every pending result
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (inside_q.size() != 0)
			@(posedge clk);
	endtask

	// fresh planes are all zero and never cull
	task automatic test_reset_planes();
		send_req(mk_test(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		send_req(mk_test(0, 0, 0, 0, 0, 0));
	endtask

	// loads beyond the plane count are dropped
	task automatic test_plane_index();
		send_req(mk_load(3'd6, 16384, 0, 0, 48'sh7FFF_FFFF_FFFF));
		send_req(mk_load(3'd7, 16384, 0, 0, 48'sh7FFF_FFFF_FFFF));
		send_req(mk_test(0, 0, 0, 65536, 65536, 65536));
		send_req(mk_load(3'd5, 16384, 0, 0, 48'sh7FFF_FFFF_FFFF));
		send_req(mk_test(0, 0, 0, 65536, 65536, 65536));
		send_req(mk_load(3'd5, 0, 0, 0, 0));
	endtask

	// corner exactly on the plane counts as in, one step past it does not
	task automatic test_on_plane();
		longint o;
		o = longint'(16384) * (3 * 65536);
		send_req(mk_load(3'd0, 16384, 0, 0, o[47:0]));
		send_req(mk_test(2 * 65536, -65536, -65536, 3 * 65536, 65536, 65536));
		send_req(mk_test(2 * 65536, -65536, -65536, 3 * 65536 - 1, 65536, 65536));
		// oblique plane, box collapsed onto its origin
		o = longint'(-16384) * (5 * 65536) + longint'(8192) * (-2 * 65536)
			+ longint'(12345) * 123457;
		send_req(mk_load(3'd0, -16384, 8192, 12345, o[47:0]));
		send_req(mk_test(5 * 65536, -2 * 65536, 123457, 5 * 65536, -2 * 65536, 123457));
		send_req(mk_test(5 * 65536 + 1, -2 * 65536, 123457, 5 * 65536 + 1, -2 * 65536, 123457));
		send_req(mk_load(3'd0, 0, 0, 0, 0));
	endtask

	// out-of-range normals, extreme offsets, extreme and inverted boxes
	task automatic test_extremes();
		send_req(mk_load(3'd1, 16'sh8000, 16'sh7FFF, -16384, 48'sh8000_0000_0000));
		send_req(mk_test(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		send_req(mk_test(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send_req(mk_load(3'd1, 16384, 16384, 16384, 48'sh7FFF_FFFF_FFFF));
		send_req(mk_test(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		send_req(mk_load(3'd1, -16384, -16384, -16384, 48'sh7FFF_FFFF_FFFF));
		send_req(mk_test(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send_req(mk_load(3'd1, 0, 0, 0, 0));
	endtask

	// mostly well-formed plane/box traffic, some raw noise and boundary pairs
	task automatic test_random_stream(input int n, input int pct);
		int        target;
		int        sel;
		int        axis;
		int        ext;
		int        t;
		int        lo [3];
		int        hi [3];
		int        org [3];
		int        nrm [3];
		longint    dot;
		cull_req_t r;
		idle_pct = pct;
		target   = eff_cnt + n;
		while (eff_cnt < target) begin
			sel = $urandom_range(0, 99);
			// random direction, or an axis-aligned one a quarter of the time
			if ($urandom_range(0, 3) == 0) begin
				axis = $urandom_range(0, 2);
				for (int a = 0; a < 3; a++)
					nrm[a] = (a == axis) ? ($urandom_range(0, 1) ? 16384 : -16384) : 0;
			end else begin
				for (int a = 0; a < 3; a++)
					nrm[a] = rand_span(16384);
			end
			// box from center and extent, extent class picked at random
			case ($urandom_range(0, 2))
				0: ext = 1 << 16;
				1: ext = 1 << 21;
				default: ext = 1 << 25;
			endcase
			for (int a = 0; a < 3; a++) begin
				org[a] = rand_span(1 << 24);
				t      = $urandom_range(0, ext);
				lo[a]  = rand_span(1 << 24) - t;
				hi[a]  = lo[a] + 2 * t;
			end
			if (sel < 20) begin
				dot = 0;
				for (int a = 0; a < 3; a++)
					dot += longint'(nrm[a]) * org[a];
				send_req(mk_load(3'($urandom_range(0, 5)), 16'(nrm[0]), 16'(nrm[1]),
					16'(nrm[2]), dot[47:0]));
			end else if (sel < 25) begin
				send_req(mk_load(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
					16'($urandom), 48'({$urandom, $urandom})));
			end else if (sel < 33) begin
				// plane just touching the box's leading corner, then one unit past it
				dot = 0;
				for (int a = 0; a < 3; a++)
					dot += longint'(nrm[a]) * ((nrm[a] >= 0) ? hi[a] : lo[a]);
				axis = $urandom_range(0, 5);
				send_req(mk_load(3'(axis), 16'(nrm[0]), 16'(nrm[1]), 16'(nrm[2]), dot[47:0]));
				send_req(mk_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
				dot += 1;
				send_req(mk_load(3'(axis), 16'(nrm[0]), 16'(nrm[1]), 16'(nrm[2]), dot[47:0]));
				send_req(mk_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
			end else if (sel < 40) begin
				send_req(mk_test($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
			end else begin
				r = mk_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
				if ($urandom_range(0, 9) == 0) begin
					r.min_x = hi[0];
					r.max_x = lo[0];
				end
				send_req(r);
			end
		end
	endtask

	// sender holds off until the pipeline is empty, then resumes
	task automatic test_drain_pause();
		drain_results();
		send_req(mk_test(0, 0, 0, 65536, 65536, 65536));
	endtask

	// result checker: every strobe must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (inside_q.size() == 0) begin
				$display("%0t: result strobe with nothing pending: expected none, actual %0b",
					$time, inside_res);
				err_cnt++;
			end else begin
				inside_want = inside_q.pop_front();
				if (inside_res !== inside_want) begin
					$display("%0t: inside_res mismatch: expected %0b, actual %0b",
						$time, inside_want, inside_res);
					err_cnt++;
				end
				if (inside_want)
					kept_cnt++;
				else
					culled_cnt++;
			end
		end
	end

	// watchdog on cycles with no transfer and no result
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy && arst_n) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no activity for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// test sequence
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = REQ_LOAD;
		plane_index  = '0;
		normal_x     = '0;
		normal_y     = '0;
		normal_z     = '0;
		plane_offset = '0;
		box_min_x    = '0;
		box_min_y    = '0;
		box_min_z    = '0;
		box_max_x    = '0;
		box_max_y    = '0;
		box_max_z    = '0;
		for (int p = 0; p < PLANE_COUNT_DEF; p++)
			plane_tbl[p] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_pct = 16;
		test_reset_planes();
		test_plane_index();
		test_on_plane();
		test_extremes();
		test_random_stream(180, 16);
		test_drain_pause();
		test_random_stream(180, 65);
		test_random_stream(180, 0);

		drain_results();
		repeat (RESULT_LATENCY + 4) @(posedge clk);
		if (inside_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, inside_q.size());
			err_cnt++;
		end

		$display("Covered %0d plane loads (%0d dropped by index), %0d box tests: %0d kept, %0d culled.",
			load_cnt, ignored_cnt, test_cnt, kept_cnt, culled_cnt);
		$display("Idle profiles 16%%, 65%% and none, one full drain pause; %0d errors.", err_cnt);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
